@@ rtl/core/smd_pkg.sv @@
`default_nettype none
package smd_pkg;

  localparam int unsigned WIDTH     = 32;
  // product magnitude is at most 2^62, product plus half divisor stays below 2^63
  localparam int unsigned WORK_W    = 2 * WIDTH - 1;
  localparam int unsigned DIV_STEPS = WIDTH - 1;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WIDTH-1:0] POS_INF = 32'h7FFF_FFFF;
  localparam logic [WIDTH-1:0] NEG_INF = 32'h8000_0000;

  typedef logic [WIDTH-1:0]  word_t;
  typedef logic [WORK_W-1:0] work_t;

  function automatic word_t magnitude(input word_t v);
    magnitude = v[WIDTH-1] ? (~v + word_t'(1)) : v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/smd_in_if.sv @@
`default_nettype none
interface smd_in_if;
  logic          valid;
  logic          ready;
  smd_pkg::word_t multiplicand;
  smd_pkg::word_t multiplier;
  smd_pkg::word_t divisor;

  modport source (output valid, output multiplicand, output multiplier, output divisor,
                  input ready);
  modport sink (input valid, input multiplicand, input multiplier, input divisor,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/smd_out_if.sv @@
`default_nettype none
interface smd_out_if;
  logic          valid;
  logic          ready;
  smd_pkg::word_t quotient;
  logic          saturated;

  modport source (output valid, output quotient, output saturated, input ready);
  modport sink (input valid, input quotient, input saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/core/signed_muldiv_rounded_unit.sv @@
`default_nettype none
// Signed rounded multiply-divide: quotient = a*b/c, rounded to nearest with halves
// away from zero. An item runs from the operand transfer to the result being offered
// through a multiply, a rounding add, a range check, 31 divide steps and a
// writeback; an item that saturates (overflow or zero divisor) skips the divide steps.
// The bit-serial restoring divide runs one quotient bit per cycle through a
// single compare-subtract unit. Operands are taken only while the
// unit is idle; a finished result sits in an output register, so the next operand
// transfer can happen while that result waits. On overflow or a zero divisor the
// quotient is 0x7FFFFFFF or 0x80000000 by sign and saturated is high.
module signed_muldiv_rounded_unit (
  input wire logic clk,
  input wire logic rst,
  smd_in_if.sink   operands,
  smd_out_if.source result
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ADD  = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_WB   = 6'b100000
  } state_t;

  localparam logic [smd_pkg::CNT_W-1:0] LAST_STEP = smd_pkg::CNT_W'(smd_pkg::DIV_STEPS - 1);

  state_t                    state;
  smd_pkg::word_t            ma;
  smd_pkg::word_t            mb;
  smd_pkg::word_t            mc;
  logic                      neg;
  smd_pkg::work_t            work;
  logic [smd_pkg::CNT_W-1:0] count;
  smd_pkg::word_t            res_q;
  logic                      res_sat;

  logic [2*smd_pkg::WIDTH-1:0] product;
  logic                        overflow;
  smd_pkg::word_t              rem_next;
  logic                        q_bit;
  logic [smd_pkg::WIDTH-1:0]   q_word;
  logic                        out_free;
  logic                        accept;

  assign accept   = operands.valid && operands.ready;
  assign out_free = !result.valid || result.ready;
  assign product  = {smd_pkg::WIDTH'(0), ma} * {smd_pkg::WIDTH'(0), mb};
  assign overflow = work >= {mc, smd_pkg::DIV_STEPS'(0)};
  assign q_word   = {1'b0, work[smd_pkg::DIV_STEPS-1:0]};

  smd_div_step u_step (
    .remainder      (work[smd_pkg::WORK_W-1:smd_pkg::DIV_STEPS]),
    .bit_in         (work[smd_pkg::DIV_STEPS-1]),
    .divisor        (mc),
    .remainder_next (rem_next),
    .quotient_bit   (q_bit)
  );

  assign operands.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      // writeback reloads valid on its own
      if (result.valid && result.ready && state != ST_WB) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          count <= '0;
          state <= overflow ? ST_WB : ST_DIV;
        end
        ST_DIV: begin
          count <= count + 1'b1;
          if (count == LAST_STEP) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            result.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ma  <= smd_pkg::magnitude(operands.multiplicand);
          mb  <= smd_pkg::magnitude(operands.multiplier);
          mc  <= smd_pkg::magnitude(operands.divisor);
          // a zero product counts as non-negative
          neg <= ((operands.multiplicand != '0) && (operands.multiplier != '0) &&
                  (operands.multiplicand[smd_pkg::WIDTH-1] ^
                   operands.multiplier[smd_pkg::WIDTH-1])) ^ operands.divisor[smd_pkg::WIDTH-1];
        end
      end
      ST_MUL: begin
        work <= product[smd_pkg::WORK_W-1:0];
      end
      ST_ADD: begin
        work <= work + {smd_pkg::DIV_STEPS'(0), 1'b0, mc[smd_pkg::WIDTH-1:1]};
      end
      ST_CMP: begin
        if (overflow) begin
          res_q   <= neg ? smd_pkg::NEG_INF : smd_pkg::POS_INF;
          res_sat <= 1'b1;
        end
      end
      ST_DIV: begin
        // high part is the running remainder, low part shifts in quotient bits
        work <= {rem_next, work[smd_pkg::DIV_STEPS-2:0], q_bit};
        if (count == LAST_STEP) begin
          res_sat <= 1'b0;
          res_q   <= neg ? (~{1'b0, work[smd_pkg::DIV_STEPS-2:0], q_bit} + smd_pkg::word_t'(1))
                         : {1'b0, work[smd_pkg::DIV_STEPS-2:0], q_bit};
        end
      end
      ST_WB: begin
        if (out_free) begin
          result.quotient  <= res_q;
          result.saturated <= res_sat;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MUL)
    else $error("operand transfer did not start the multiply");

  a_zero_div_sat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && mc == '0) |=> res_sat)
    else $error("zero divisor did not saturate");

  a_sign_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB && !res_sat && res_q != '0) |-> res_q[smd_pkg::WIDTH-1] == neg)
    else $error("quotient sign does not match operand signs");

  a_div_quot_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && count == '0) |-> q_word[smd_pkg::WIDTH-1] == 1'b0 &&
      work[smd_pkg::WORK_W-1:smd_pkg::DIV_STEPS] < mc)
    else $error("divide started with remainder not below divisor");
`endif

endmodule
`default_nettype wire

@@ rtl/core/smd_div_step.sv @@
`default_nettype none
module smd_div_step (
  input  wire smd_pkg::word_t remainder,
  input  wire logic           bit_in,
  input  wire smd_pkg::word_t divisor,
  output smd_pkg::word_t      remainder_next,
  output logic                quotient_bit
);

  logic [smd_pkg::WIDTH:0] shifted;
  logic [smd_pkg::WIDTH:0] trial;

  // restoring step: remainder is always below divisor, so one subtract decides the bit
  always_comb begin
    shifted        = {remainder, bit_in};
    trial          = shifted - {1'b0, divisor};
    quotient_bit   = ~trial[smd_pkg::WIDTH];
    remainder_next = quotient_bit ? trial[smd_pkg::WIDTH-1:0] : shifted[smd_pkg::WIDTH-1:0];
  end

endmodule
`default_nettype wire
